// ===== src/npcm_pkg.sv =====
package npcm_pkg;

  // Table geometry.
  localparam int NUM_THEMES      = 4;
  localparam int SLOTS_PER_THEME = 16;
  localparam int TABLE_DEPTH     = NUM_THEMES * SLOTS_PER_THEME;
  localparam int ADDR_W          = $clog2(TABLE_DEPTH);

  // Field widths.
  localparam int THEME_W = 2;
  localparam int SLOT_W  = 4;
  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 3 * CHAN_W;
  localparam int SQ_W    = 2 * CHAN_W;
  localparam int DIST_W  = 18;

  // Input tdata layout, lowest bit first.
  localparam int IN_THEME_LSB = 0;
  localparam int IN_SLOT_LSB  = IN_THEME_LSB + THEME_W;
  localparam int IN_VALID_LSB = IN_SLOT_LSB + SLOT_W;
  localparam int IN_COLOR_LSB = IN_VALID_LSB + 1;
  localparam int IN_USED_W    = IN_COLOR_LSB + COLOR_W;
  localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // Output tdata layout, lowest bit first.
  localparam int OUT_FOUND_LSB = 0;
  localparam int OUT_IDX_LSB   = OUT_FOUND_LSB + 1;
  localparam int OUT_DIST_LSB  = OUT_IDX_LSB + SLOT_W;
  localparam int OUT_USED_W    = OUT_DIST_LSB + DIST_W;
  localparam int OUT_DATA_W    = ((OUT_USED_W + 7) / 8) * 8;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_t;

  // Controller to datapath.
  typedef struct packed {
    logic              write;
    logic              load_query;
    logic              issue;
    logic [SLOT_W-1:0] slot;
    logic              last;
    logic              load_out;
  } npcm_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic done;
    logic out_free;
  } npcm_sts_t;

  function automatic logic [ADDR_W-1:0] tbl_addr(input logic [THEME_W-1:0] theme,
                                                 input logic [SLOT_W-1:0]  slot);
    int a;
    a = int'(theme) * SLOTS_PER_THEME + int'(slot);
    return a[ADDR_W-1:0];
  endfunction

endpackage

// ===== src/npcm_ctrl.sv =====
module npcm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tuser,
  output logic                  in_tready,
  input  npcm_pkg::npcm_sts_t   sts,
  output npcm_pkg::npcm_cmd_t   cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT
  } state_t;

  state_t                     state_r;
  logic                       in_tready_r;
  logic [npcm_pkg::SLOT_W-1:0] slot_cnt_r;
  logic                       accept;
  logic                       is_query;
  logic                       scan_last;

  assign accept    = in_tvalid && in_tready_r;
  assign is_query  = (in_tuser == npcm_pkg::REQ_QUERY);
  assign scan_last = (int'(slot_cnt_r) == npcm_pkg::SLOTS_PER_THEME - 1);
  assign in_tready = in_tready_r;

  always_comb begin
    cmd            = '0;
    cmd.write      = accept && !is_query;
    cmd.load_query = accept && is_query;
    cmd.issue      = (state_r == ST_SCAN);
    cmd.slot       = slot_cnt_r;
    cmd.last       = scan_last;
    cmd.load_out   = (state_r == ST_WAIT) && sts.done && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_tready_r <= 1'b0;
      slot_cnt_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          in_tready_r <= 1'b1;
          if (accept && is_query) begin
            state_r     <= ST_SCAN;
            in_tready_r <= 1'b0;
            slot_cnt_r  <= '0;
          end
        end
        ST_SCAN: begin
          slot_cnt_r <= slot_cnt_r + 1'b1;
          if (scan_last) begin
            state_r <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (sts.done && sts.out_free) begin
            state_r     <= ST_IDLE;
            in_tready_r <= 1'b1;
          end
        end
        default: begin
          state_r     <= ST_IDLE;
          in_tready_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== src/npcm_dp.sv =====
module npcm_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [npcm_pkg::IN_DATA_W-1:0]     in_tdata,
  input  npcm_pkg::npcm_cmd_t                cmd,
  output npcm_pkg::npcm_sts_t                sts,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [npcm_pkg::OUT_DATA_W-1:0]    out_tdata
);

  localparam int CW = npcm_pkg::CHAN_W;

  // Input fields.
  logic [npcm_pkg::THEME_W-1:0] f_theme;
  logic [npcm_pkg::SLOT_W-1:0]  f_slot;
  logic                         f_valid;
  logic [npcm_pkg::COLOR_W-1:0] f_color;

  assign f_theme = in_tdata[npcm_pkg::IN_THEME_LSB +: npcm_pkg::THEME_W];
  assign f_slot  = in_tdata[npcm_pkg::IN_SLOT_LSB  +: npcm_pkg::SLOT_W];
  assign f_valid = in_tdata[npcm_pkg::IN_VALID_LSB];
  assign f_color = in_tdata[npcm_pkg::IN_COLOR_LSB +: npcm_pkg::COLOR_W];

  // Color memory and its valid bits.
  logic [npcm_pkg::COLOR_W-1:0] mem [npcm_pkg::TABLE_DEPTH];
  logic [npcm_pkg::TABLE_DEPTH-1:0] slot_valid_r;

  logic wr_ok;
  logic [npcm_pkg::ADDR_W-1:0] wr_addr;
  logic [npcm_pkg::ADDR_W-1:0] rd_addr;

  assign wr_ok = cmd.write && (int'(f_theme) < npcm_pkg::NUM_THEMES)
                 && (int'(f_slot) < npcm_pkg::SLOTS_PER_THEME);
  assign wr_addr = npcm_pkg::tbl_addr(f_theme, f_slot);

  // Query held for the scan.
  logic [npcm_pkg::THEME_W-1:0] q_theme_r;
  logic [npcm_pkg::COLOR_W-1:0] q_color_r;
  logic                         q_theme_ok;

  assign q_theme_ok = (int'(q_theme_r) < npcm_pkg::NUM_THEMES);
  assign rd_addr    = npcm_pkg::tbl_addr(q_theme_r, cmd.slot);

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      q_theme_r <= f_theme;
      q_color_r <= f_color;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_addr] <= f_color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (wr_ok) begin
      slot_valid_r[wr_addr] <= f_valid;
    end
  end

  // Stage 1: table read.
  logic                         s1_vld_r;
  logic                         s1_last_r;
  logic                         s1_hit_r;
  logic [npcm_pkg::SLOT_W-1:0]  s1_slot_r;
  logic [npcm_pkg::COLOR_W-1:0] s1_color_r;

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      s1_color_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    s1_last_r <= cmd.last;
    s1_slot_r <= cmd.slot;
    s1_hit_r  <= q_theme_ok && slot_valid_r[rd_addr];
  end

  // Stage 2: per-channel squared differences.
  logic                         s2_vld_r;
  logic                         s2_last_r;
  logic                         s2_hit_r;
  logic [npcm_pkg::SLOT_W-1:0]  s2_slot_r;
  logic [npcm_pkg::SQ_W-1:0]    sq_r [3];
  logic [CW-1:0]                diff [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (q_color_r[c*CW +: CW] > s1_color_r[c*CW +: CW]) begin
        diff[c] = q_color_r[c*CW +: CW] - s1_color_r[c*CW +: CW];
      end else begin
        diff[c] = s1_color_r[c*CW +: CW] - q_color_r[c*CW +: CW];
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_last_r <= s1_last_r;
    s2_slot_r <= s1_slot_r;
    s2_hit_r  <= s1_hit_r;
    for (int c = 0; c < 3; c++) begin
      sq_r[c] <= diff[c] * diff[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.issue;
      s2_vld_r <= s1_vld_r;
    end
  end

  // Stage 3: sum and keep the strictly smaller distance.
  logic [npcm_pkg::DIST_W-1:0]  cand_dist;
  logic                         found_r;
  logic                         done_r;
  logic [npcm_pkg::SLOT_W-1:0]  best_idx_r;
  logic [npcm_pkg::DIST_W-1:0]  best_dist_r;

  assign cand_dist = npcm_pkg::DIST_W'(sq_r[0]) + npcm_pkg::DIST_W'(sq_r[1])
                   + npcm_pkg::DIST_W'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b0;
      done_r      <= 1'b0;
      best_idx_r  <= '0;
      best_dist_r <= '0;
    end else if (cmd.load_query) begin
      found_r     <= 1'b0;
      done_r      <= 1'b0;
      best_idx_r  <= '0;
      best_dist_r <= '0;
    end else if (s2_vld_r) begin
      if (s2_hit_r && (!found_r || cand_dist < best_dist_r)) begin
        found_r     <= 1'b1;
        best_idx_r  <= s2_slot_r;
        best_dist_r <= cand_dist;
      end
      if (s2_last_r) begin
        done_r <= 1'b1;
      end
    end
  end

  // Output register.
  logic                            out_tvalid_r;
  logic [npcm_pkg::OUT_DATA_W-1:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_tdata_r <= npcm_pkg::OUT_DATA_W'({best_dist_r, best_idx_r, found_r});
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign sts.done     = done_r;
  assign sts.out_free = !out_tvalid_r || out_tready;

endmodule

// ===== src/nearest_palette_color_match_core.sv =====
// Channel  | Ports                          | Carries
// ---------+--------------------------------+------------------------------------------
// input    | in_tvalid/in_tready/in_tdata   | table write or nearest-color query
//          | in_tuser                       | request type (write or query)
// result   | out_tvalid/out_tready/out_tdata| found flag, best slot, squared distance
//
// A write transaction is taken and produces no result.
// A query transaction reads the 16 slots of its theme one per cycle through the single
// memory read port, then squares the channel differences, sums them, compares the sum
// against the running best and loads the output register; in_tready returns as
// out_tvalid rises, so the next transaction is taken only once the query's result is out.
// The result sits in an output register; writes are taken while it waits there, and a
// following query holds in its last cycle until that register has been taken.
// Reset (rst_n low, synchronous) clears all valid marks and control state; color
// entries are never cleared, and a color only counts once its slot is written valid.
module nearest_palette_color_match_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tdata fields from bit 0: theme, entry_index, entry_valid, blue, green, red, zero pad.
  input  logic [npcm_pkg::IN_DATA_W-1:0]  in_tdata,
  // tuser fields from bit 0: req_type.
  input  logic                            in_tuser,
  // Result channel.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // tdata fields from bit 0: found, best_index, best_distance, zero pad.
  output logic [npcm_pkg::OUT_DATA_W-1:0] out_tdata
);

  npcm_pkg::npcm_cmd_t cmd;
  npcm_pkg::npcm_sts_t sts;

  // The controller sequences each transaction: it accepts writes in place,
  // and walks the slots of the queried theme one per cycle.
  npcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the color memory, the valid bits, the distance
  // pipeline, the running best and the output register.
  npcm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef NO_ASSERTIONS
  // No new transaction is taken while the scan is reading the table.
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> !in_tready)
    else $error("input accepted during a table scan");

  // A result is only loaded when the output register can take it.
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over an untaken result");

  // A query that found nothing reports slot zero and distance zero.
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[npcm_pkg::OUT_FOUND_LSB])
      |-> (out_tdata[npcm_pkg::OUT_USED_W-1:npcm_pkg::OUT_IDX_LSB] == '0))
    else $error("empty theme result carries a nonzero slot or distance");
`endif

endmodule

// ===== sim/npcm_checker.sv =====
module npcm_checker
  import npcm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [DIST_W-1:0] dist_sq;
  } match_t;

  logic [COLOR_W-1:0] palette_color [TABLE_DEPTH];
  logic               palette_live  [TABLE_DEPTH];
  match_t             match_q[$];

  function automatic logic [DIST_W-1:0] sq_dist(input logic [COLOR_W-1:0] a,
                                                input logic [COLOR_W-1:0] b);
    int sum;
    int d;
    sum = 0;
    for (int c = 0; c < 3; c++) begin
      d = int'(a[c*CHAN_W +: CHAN_W]) - int'(b[c*CHAN_W +: CHAN_W]);
      sum += d * d;
    end
    return sum[DIST_W-1:0];
  endfunction

  // Scan from the lowest slot and replace only on a strictly smaller distance.
  function automatic match_t nearest_match(input logic [THEME_W-1:0] theme,
                                           input logic [COLOR_W-1:0] color);
    match_t            best;
    logic [DIST_W-1:0] d;
    int                base;
    best = '0;
    if (int'(theme) < NUM_THEMES) begin
      base = int'(theme) * SLOTS_PER_THEME;
      for (int s = 0; s < SLOTS_PER_THEME; s++) begin
        if (palette_live[base + s]) begin
          d = sq_dist(color, palette_color[base + s]);
          if (!best.found || d < best.dist_sq) begin
            best.found   = 1'b1;
            best.dist_sq = d;
            best.slot    = SLOT_W'(s);
          end
        end
      end
    end
    return best;
  endfunction

  always @(posedge clk) begin
    match_t             got;
    match_t             want;
    int                 errs;
    logic [THEME_W-1:0] theme;
    logic [SLOT_W-1:0]  slot;
    logic [COLOR_W-1:0] color;
    if (!rst_n) begin
      for (int a = 0; a < TABLE_DEPTH; a++) begin
        palette_live[a]  = 1'b0;
        palette_color[a] = '0;
      end
      match_q.delete();
      mismatches  <= 0;
      outstanding <= 0;
    end else begin
      errs = 0;
      if (out_tvalid && out_tready) begin
        got.found   = out_tdata[OUT_FOUND_LSB];
        got.slot    = out_tdata[OUT_IDX_LSB +: SLOT_W];
        got.dist_sq = out_tdata[OUT_DIST_LSB +: DIST_W];
        if (match_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual tdata %h",
                   $time, out_tdata);
          errs++;
        end else begin
          want = match_q.pop_front();
          if (got.found !== want.found) begin
            $display("%0t: found mismatch, expected %0d, actual %0d",
                     $time, want.found, got.found);
            errs++;
          end
          if (got.slot !== want.slot) begin
            $display("%0t: best_index mismatch, expected %0d, actual %0d",
                     $time, want.slot, got.slot);
            errs++;
          end
          if (got.dist_sq !== want.dist_sq) begin
            $display("%0t: best_distance mismatch, expected %0d, actual %0d",
                     $time, want.dist_sq, got.dist_sq);
            errs++;
          end
          if (out_tdata[OUT_DATA_W-1:OUT_USED_W] !== '0) begin
            $display("%0t: tdata pad mismatch, expected 0, actual %h",
                     $time, out_tdata[OUT_DATA_W-1:OUT_USED_W]);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        theme = in_tdata[IN_THEME_LSB +: THEME_W];
        slot  = in_tdata[IN_SLOT_LSB +: SLOT_W];
        color = in_tdata[IN_COLOR_LSB +: COLOR_W];
        if (in_tuser == REQ_QUERY) begin
          match_q.insert(match_q.size(), nearest_match(theme, color));
        end else if (int'(theme) < NUM_THEMES && int'(slot) < SLOTS_PER_THEME) begin
          palette_color[tbl_addr(theme, slot)] = color;
          palette_live[tbl_addr(theme, slot)]  = in_tdata[IN_VALID_LSB];
        end
      end
      mismatches  <= mismatches + errs;
      outstanding <= match_q.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// Top of the nearest palette color match testbench. This module only makes
// stimulus and gives the verdict; the checker beside the block watches both
// channels, keeps its own copy of the palette table, and compares every
// result transaction against the nearest match it worked out itself.
module tb;
  import npcm_pkg::*;

  // Random steps after the directed part; a few of them clear a whole theme,
  // so the input transactions come to about 1.5 per step.
  localparam int RANDOM_ITEMS = 800;
  // The last items run with neither side idling.
  localparam int QUIET_TAIL   = 150;
  // Cycles without any transaction before the run is called hung.
  localparam int STALL_LIMIT  = 2000;
  // Cycles to watch for stray results once nothing is expected any more.
  localparam int DRAIN_CYCLES = 40;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int mismatches;
  int outstanding;
  int idle_run = 0;
  // Set for the tail of the run; both sides stop idling.
  bit quiet = 1'b0;
  // A few shared colors so that random queries often hit exact ties.
  logic [COLOR_W-1:0] shared_colors [8];

  always #5 clk = ~clk;

  nearest_palette_color_match_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  npcm_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Present one transaction at the falling edge and hold it until the block
  // takes it. tvalid stays high afterwards; hold_off lowers it when a gap
  // follows, always at a later falling edge.
  task automatic send_item(input req_type_t          req,
                           input logic [THEME_W-1:0] theme,
                           input logic [SLOT_W-1:0]  slot,
                           input logic               live,
                           input logic [COLOR_W-1:0] color);
    logic [IN_DATA_W-1:0] word;
    word = '0;
    word[IN_THEME_LSB +: THEME_W] = theme;
    word[IN_SLOT_LSB +: SLOT_W]   = slot;
    word[IN_VALID_LSB]            = live;
    word[IN_COLOR_LSB +: COLOR_W] = color;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  // Stop sending until every query in flight has produced its result.
  task automatic wait_drained();
    hold_off(1);
    while (outstanding != 0) @(negedge clk);
  endtask

  // Channel values lean toward the extremes so that both ends get plenty of hits.
  function automatic logic [CHAN_W-1:0] pick_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color();
    if ($urandom_range(0, 3) == 0) begin
      return shared_colors[$urandom_range(0, 7)];
    end
    return {pick_chan(), pick_chan(), pick_chan()};
  endfunction

  // Result side: ready comes in random bursts, now and then a long stretch of
  // ready, and is held high once the quiet tail begins.
  initial begin
    int len;
    bit rdy;
    forever begin
      rdy = $urandom_range(0, 2) != 0;
      len = $urandom_range(1, 18);
      if (rdy && $urandom_range(0, 9) == 0) begin
        len = 150;
      end
      repeat (len) begin
        @(negedge clk);
        out_tready <= quiet ? 1'b1 : rdy;
      end
    end
  end

  // Watchdog: any cycle that moves a transaction on either channel restarts it.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_run <= 0;
    end else if (idle_run >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    int                 roll;
    bit                 gappy;
    logic [THEME_W-1:0] theme;
    for (int k = 0; k < 8; k++) begin
      shared_colors[k] = COLOR_W'($urandom);
    end
    gappy = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. A query on a theme that was never written finds nothing.
    send_item(REQ_QUERY, 2'd0, 4'd15, 1'b1, 24'h000000);
    // Opposite corners of the color cube in the lowest and highest slot.
    send_item(REQ_WRITE, 2'd0, 4'd0, 1'b1, 24'h000000);
    send_item(REQ_WRITE, 2'd0, 4'd15, 1'b1, 24'hffffff);
    send_item(REQ_QUERY, 2'd0, 4'd0, 1'b0, 24'h000000);
    send_item(REQ_QUERY, 2'd0, 4'd0, 1'b0, 24'hffffff);
    send_item(REQ_QUERY, 2'd0, 4'd0, 1'b0, 24'h0000ff);
    // Largest possible distance.
    send_item(REQ_WRITE, 2'd1, 4'd3, 1'b1, 24'h000000);
    send_item(REQ_QUERY, 2'd1, 4'd0, 1'b0, 24'hffffff);
    // Two slots with the same color: the lower slot must win the tie.
    send_item(REQ_WRITE, 2'd2, 4'd4, 1'b1, 24'h123456);
    send_item(REQ_WRITE, 2'd2, 4'd9, 1'b1, 24'h123456);
    send_item(REQ_QUERY, 2'd2, 4'd0, 1'b0, 24'h123450);
    // Different colors at the same distance also go to the lower slot.
    send_item(REQ_WRITE, 2'd3, 4'd5, 1'b1, 24'h00000a);
    send_item(REQ_WRITE, 2'd3, 4'd6, 1'b1, 24'h00001e);
    send_item(REQ_QUERY, 2'd3, 4'd0, 1'b0, 24'h000014);
    // Removing the tie winner hands the match to the other slot.
    send_item(REQ_WRITE, 2'd2, 4'd4, 1'b0, 24'habcdef);
    send_item(REQ_QUERY, 2'd2, 4'd0, 1'b0, 24'h123456);
    // A slot written as not present is skipped even on an exact hit; the
    // slot and valid fields of a query carry junk here and must be ignored.
    send_item(REQ_WRITE, 2'd3, 4'd7, 1'b0, 24'h000014);
    send_item(REQ_QUERY, 2'd3, 4'd7, 1'b1, 24'h000014);
    // Emptying a theme again brings back the not-found answer.
    send_item(REQ_WRITE, 2'd1, 4'd3, 1'b0, 24'h000000);
    send_item(REQ_QUERY, 2'd1, 4'd3, 1'b1, 24'hffffff);
    wait_drained();

    // Random part: mostly writes and queries, sometimes a whole theme cleared
    // and queried so that the empty case keeps coming back.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= RANDOM_ITEMS - QUIET_TAIL);
      if (i % 100 == 0) begin
        gappy = $urandom_range(0, 2) != 0;
      end
      if (i == RANDOM_ITEMS / 2) begin
        wait_drained();
      end
      roll  = $urandom_range(0, 99);
      theme = THEME_W'($urandom);
      if (roll < 3) begin
        for (int s = 0; s < SLOTS_PER_THEME; s++) begin
          send_item(REQ_WRITE, theme, SLOT_W'(s), 1'b0, pick_color());
        end
        send_item(REQ_QUERY, theme, SLOT_W'($urandom), 1'($urandom), pick_color());
      end else if (roll < 43) begin
        send_item(REQ_WRITE, theme, SLOT_W'($urandom), $urandom_range(0, 4) != 0,
                  pick_color());
      end else begin
        send_item(REQ_QUERY, theme, SLOT_W'($urandom), 1'($urandom), pick_color());
      end
      if (!quiet && gappy && $urandom_range(0, 3) == 0) begin
        hold_off($urandom_range(1, 18));
      end
    end

    // Wait for the last results, then watch a while for anything extra.
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
